// File: sv/ptb_pkg.sv
package ptb_pkg;

	localparam int NUM_TIMERS  = 16;
	localparam int IDX_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CNT_W       = $clog2(NUM_TIMERS + 1);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic KIND_EXPIRY = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	typedef enum logic [2:0] {
		MODE_TICK          = 3'd0,
		MODE_SCAN          = 3'd1,
		MODE_SET           = 3'd2,
		MODE_SET_IF_ACTIVE = 3'd3,
		MODE_CANCEL        = 3'd4,
		MODE_QUERY         = 3'd5
	} mode_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [7:0]  timer_index;
		logic [15:0] period;
		logic [15:0] user_data;
	} req_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  fired_index;
		logic [15:0] fired_data;
		logic        is_active;
		logic        last_result;
	} rsp_t;

	// classified request as it sits in the queue
	typedef struct packed {
		mode_t       mode;
		logic        in_range;
		logic [7:0]  timer_index;
		logic [15:0] period;
		logic [15:0] user_data;
	} cmd_t;

endpackage

// File: sv/ptb_front.sv
module ptb_front import ptb_pkg::*; (
	input  logic start,
	input  req_t request,
	input  logic full,
	output logic busy,
	output logic push,
	output cmd_t push_cmd
);

	logic known;

	// modes above query do nothing and never enter the queue
	assign known = (request.mode <= MODE_QUERY);
	assign busy  = full;
	assign push  = start && !full && known;

	always_comb begin
		push_cmd.mode        = mode_t'(request.mode);
		push_cmd.in_range    = (request.timer_index < 8'(NUM_TIMERS));
		push_cmd.timer_index = request.timer_index;
		push_cmd.period      = request.period;
		push_cmd.user_data   = request.user_data;
	end

endmodule

// File: sv/ptb_queue.sv
module ptb_queue import ptb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic empty,
	output logic full
);

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// File: sv/ptb_back.sv
module ptb_back import ptb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic empty,
	input  cmd_t head,
	output logic pop,
	output logic result_valid,
	output rsp_t result
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

	state_t           state_q;
	logic [15:0]      time_q;
	logic [15:0]      per_q [NUM_TIMERS];
	logic [15:0]      stamp_mem [NUM_TIMERS];
	logic [15:0]      word_mem [NUM_TIMERS];

	logic [CNT_W-1:0] rd_idx_q;
	logic             valid_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [15:0]      stamp_s1;
	logic [15:0]      word_s1;

	logic             pend_q;
	logic [IDX_W-1:0] pend_idx_q;
	logic [15:0]      pend_word_q;

	logic             res_valid_q;
	rsp_t             res_q;

	logic [IDX_W-1:0] head_idx;
	logic [15:0]      head_per;
	logic             rd_issue;
	logic [IDX_W-1:0] rd_addr;
	logic [15:0]      s1_per;
	logic [15:0]      elapsed;
	logic             expire;
	logic             st_we;
	logic [IDX_W-1:0] st_waddr;
	logic             wd_we;
	logic             emit_v;
	rsp_t             emit_rsp;
	logic             scan_end;

	assign pop      = (state_q == ST_IDLE) && !empty;
	assign head_idx = head.timer_index[IDX_W-1:0];
	assign head_per = per_q[head_idx];

	always_comb begin
		rd_issue = 1'b0;
		rd_addr  = '0;
		case (state_q)
			ST_IDLE: begin
				rd_issue = pop && (head.mode == MODE_SCAN);
			end
			ST_SCAN: begin
				rd_issue = (rd_idx_q < CNT_W'(NUM_TIMERS));
				rd_addr  = rd_idx_q[IDX_W-1:0];
			end
			default: begin
				rd_issue = 1'b0;
			end
		endcase
	end

	// expiry test on the entry read in the previous cycle, wrapped elapsed time
	assign s1_per   = per_q[idx_s1];
	assign elapsed  = time_q - stamp_s1;
	assign expire   = (state_q == ST_SCAN) && valid_s1 && (s1_per != 16'd0)
		&& (elapsed > s1_per);
	assign scan_end = valid_s1 && (idx_s1 == IDX_W'(NUM_TIMERS - 1));

	always_comb begin
		st_we    = 1'b0;
		st_waddr = head_idx;
		wd_we    = 1'b0;
		if (pop && head.in_range) begin
			case (head.mode)
				MODE_SET: begin
					st_we = 1'b1;
					wd_we = 1'b1;
				end
				MODE_SET_IF_ACTIVE: begin
					wd_we = (head_per != 16'd0);
				end
				default: begin
					wd_we = 1'b0;
				end
			endcase
		end
		if (expire) begin
			st_we    = 1'b1;
			st_waddr = idx_s1;
		end
	end

	// an expiry is held back until the next expiry or the flush so the final one can carry last_result
	always_comb begin
		emit_v   = 1'b0;
		emit_rsp = '0;
		if (pop && (head.mode == MODE_QUERY)) begin
			emit_v               = 1'b1;
			emit_rsp.kind        = KIND_QUERY;
			emit_rsp.fired_index = head.timer_index;
			emit_rsp.is_active   = head.in_range && (head_per != 16'd0);
			emit_rsp.last_result = 1'b1;
		end else if ((expire || state_q == ST_FLUSH) && pend_q) begin
			emit_v               = 1'b1;
			emit_rsp.kind        = KIND_EXPIRY;
			emit_rsp.fired_index = 8'(pend_idx_q);
			emit_rsp.fired_data  = pend_word_q;
			emit_rsp.is_active   = 1'b1;
			emit_rsp.last_result = (state_q == ST_FLUSH);
		end
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			stamp_mem[st_waddr] <= time_q;
		end
		if (wd_we) begin
			word_mem[head_idx] <= head.user_data;
		end
		if (rd_issue) begin
			stamp_s1 <= stamp_mem[rd_addr];
			word_s1  <= word_mem[rd_addr];
			idx_s1   <= rd_addr;
		end
		if (expire) begin
			pend_idx_q  <= idx_s1;
			pend_word_q <= word_s1;
		end
		if (emit_v) begin
			res_q <= emit_rsp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				per_q[i] <= '0;
			end
		end else if (pop) begin
			case (head.mode)
				MODE_TICK: begin
					time_q <= time_q + 16'd1;
				end
				MODE_SET: begin
					if (head.in_range) begin
						per_q[head_idx] <= head.period;
					end
				end
				MODE_SET_IF_ACTIVE: begin
					if (head.in_range && head_per != 16'd0) begin
						per_q[head_idx] <= 16'd1;
					end
				end
				MODE_CANCEL: begin
					if (head.in_range) begin
						per_q[head_idx] <= 16'd0;
					end
				end
				default: begin
					time_q <= time_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_idx_q    <= '0;
			valid_s1    <= 1'b0;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= emit_v;
			case (state_q)
				ST_IDLE: begin
					if (rd_issue) begin
						state_q  <= ST_SCAN;
						rd_idx_q <= CNT_W'(1);
						valid_s1 <= 1'b1;
						pend_q   <= 1'b0;
					end
				end
				ST_SCAN: begin
					valid_s1 <= rd_issue;
					if (rd_issue) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					if (expire) begin
						pend_q <= 1'b1;
					end
					if (scan_end) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					pend_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

// File: sv/periodic_timer_bank.sv
// a query answer is formed as the query is popped from the queue and leaves through the result register
// tick, set, set-if-active, cancel and query complete as the back end pops them;
// a scan does one stamp/word memory read per timer, then a flush, and pops nothing until idle
// a 4-entry queue takes requests while the back end works; busy means the queue is full
// reset: time zero, every timer inactive, queue empty, no clearing pass
// results cannot be stalled: each one is on the result ports for exactly one cycle
module periodic_timer_bank import ptb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t request,
	output logic busy,
	output logic result_valid,
	output rsp_t result
);

	logic push;
	cmd_t push_cmd;
	logic pop;
	cmd_t head;
	logic empty;
	logic full;

	ptb_front u_front (
		.start    (start),
		.request  (request),
		.full     (full),
		.busy     (busy),
		.push     (push),
		.push_cmd (push_cmd)
	);

	ptb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	ptb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result       (result)
	);

	a_query_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_QUERY |-> result.last_result)
		else $error("query answer without last marker");

	a_expiry_active: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_EXPIRY |-> result.is_active)
		else $error("expiry result from an inactive timer");

	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(push))
		else $error("queue went full without a request");

	a_query_resp: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head.mode == MODE_QUERY |=> result_valid && result.kind == KIND_QUERY)
		else $error("query popped without an answer");

endmodule
